/* src/cfpt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera frustum point test package
// Shared constants, register indexes, result codes and pipeline types.
// ----------------------------------------------------------------------------
package cfpt_pkg;

  // Default camera intrinsics, in pixels.
  localparam int FocalXDefault  = 600;
  localparam int FocalYDefault  = 600;
  localparam int CenterXDefault = 320;
  localparam int CenterYDefault = 240;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 32;
  localparam int CoordW    = 32;
  localparam int TrigW     = 16;
  localparam int RangeW    = 31;

  // Largest magnitude of a Q2.14 trig value (1.0).
  localparam int TrigOne = 16384;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_COS_ABOUT_Y = 3'd0,
    CFG_SIN_ABOUT_Y = 3'd1,
    CFG_COS_ABOUT_X = 3'd2,
    CFG_SIN_ABOUT_X = 3'd3,
    CFG_CAMERA_X    = 3'd4,
    CFG_CAMERA_Y    = 3'd5,
    CFG_CAMERA_Z    = 3'd6,
    CFG_RANGE_LIMIT = 3'd7
  } cfg_index_e;

  typedef enum logic [1:0] {
    REASON_VISIBLE = 2'd0,
    REASON_RANGE   = 2'd1,
    REASON_DEPTH   = 2'd2,
    REASON_IMAGE   = 2'd3
  } reason_e;

  // Rejection flags that travel with an item down the pipeline.
  typedef struct packed {
    logic beyond;
    logic zero;
    logic ovf;
  } flags_t;

  // One predicted result item.
  typedef struct packed {
    logic    in_view;
    reason_e reason;
  } verdict_t;

endpackage

/* src/camera_frustum_point_test_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera frustum point test
// Pipelined visibility test of world points against a posed pinhole camera.
// ----------------------------------------------------------------------------
// Usage: software writes the camera pose (Q2.14 trig values, Q16.16 position)
// and the range limit through the configuration port, which is always ready;
// software must write it only while no item is in flight, as the block does
// not enforce this. Points then stream in on the input channel, one Q16.16
// item per cycle while the input is not stalled. Every point produces exactly
// one result item carrying in_view and a two-bit reject reason. Throughput is
// one item per cycle unless the receiver stalls. The restoring divider
// resolves one quotient bit per stage for 31 stages.
// Reset clears every valid bit and loads the register defaults (identity
// rotation, camera at the origin, range limit zero).
// When the receiver stalls a waiting result, the whole pipeline freezes and
// the input stall follows at once, so no item is lost or repeated. The input
// stall is only raised while a result waits on a stalled output.
// ----------------------------------------------------------------------------
module camera_frustum_point_test_top #(
  parameter int FOCAL_X  = cfpt_pkg::FocalXDefault,
  parameter int FOCAL_Y  = cfpt_pkg::FocalYDefault,
  parameter int CENTER_X = cfpt_pkg::CenterXDefault,
  parameter int CENTER_Y = cfpt_pkg::CenterYDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cfpt_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [cfpt_pkg::CfgDataW-1:0]  cfg_data_i,
  // Point input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [31:0]             point_x_i,
  input  logic signed [31:0]             point_y_i,
  input  logic signed [31:0]             point_z_i,
  // Result output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           in_view_o,
  output logic [1:0]                     reject_reason_o
);

  // Quotient bits: the Q15.16 ratio magnitude stays below 2^31.
  localparam int NDiv = 31;
  // Magnitudes of the rotated coordinates stay below 2^62.
  localparam int MagW = 63;
  // Remainder width holds the divisor shifted by up to NDiv-1 places.
  localparam int RemW = MagW + NDiv;
  localparam int PixW = 50;
  localparam longint UpperX = longint'(2 * CENTER_X - 1) * 65536;
  localparam longint UpperY = longint'(2 * CENTER_Y - 1) * 65536;

  // --------------------------------------------------------------------------
  // Configuration registers. Trig values are clamped to +-1.0 when written.
  // --------------------------------------------------------------------------
  logic signed [15:0] ca_q, sa_q, cb_q, sb_q;
  logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
  logic [30:0]        range_q;

  function automatic logic signed [15:0] clamp_trig(input logic signed [15:0] v);
    logic signed [15:0] r;
    r = v;
    if (v > 16'(cfpt_pkg::TrigOne)) begin
      r = 16'(cfpt_pkg::TrigOne);
    end else if (v < -16'(cfpt_pkg::TrigOne)) begin
      r = -16'(cfpt_pkg::TrigOne);
    end
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ca_q    <= 16'(cfpt_pkg::TrigOne);
      sa_q    <= '0;
      cb_q    <= 16'(cfpt_pkg::TrigOne);
      sb_q    <= '0;
      cam_x_q <= '0;
      cam_y_q <= '0;
      cam_z_q <= '0;
      range_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfpt_pkg::cfg_index_e'(cfg_index_i))
        cfpt_pkg::CFG_COS_ABOUT_Y: ca_q    <= clamp_trig(cfg_data_i[15:0]);
        cfpt_pkg::CFG_SIN_ABOUT_Y: sa_q    <= clamp_trig(cfg_data_i[15:0]);
        cfpt_pkg::CFG_COS_ABOUT_X: cb_q    <= clamp_trig(cfg_data_i[15:0]);
        cfpt_pkg::CFG_SIN_ABOUT_X: sb_q    <= clamp_trig(cfg_data_i[15:0]);
        cfpt_pkg::CFG_CAMERA_X:    cam_x_q <= cfg_data_i;
        cfpt_pkg::CFG_CAMERA_Y:    cam_y_q <= cfg_data_i;
        cfpt_pkg::CFG_CAMERA_Z:    cam_z_q <= cfg_data_i;
        cfpt_pkg::CFG_RANGE_LIMIT: range_q <= cfg_data_i[30:0];
      endcase
    end
  end

  // Coefficients derived from the pose, registered from the configuration registers.
  // The block must be kept idle across configuration writes (it does not enforce this), so the lag is harmless.
  logic signed [29:0] k_sasb_q, k_sacb_q, k_casb_q, k_cacb_q;
  logic [61:0]        r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_sasb_q <= '0;
      k_sacb_q <= '0;
      k_casb_q <= '0;
      k_cacb_q <= 30'(cfpt_pkg::TrigOne * cfpt_pkg::TrigOne);
      r2_q     <= '0;
    end else begin
      k_sasb_q <= 30'(32'(sa_q) * 32'(sb_q));
      k_sacb_q <= 30'(32'(sa_q) * 32'(cb_q));
      k_casb_q <= 30'(32'(ca_q) * 32'(sb_q));
      k_cacb_q <= 30'(32'(ca_q) * 32'(cb_q));
      r2_q     <= 62'(range_q) * 62'(range_q);
    end
  end

  // --------------------------------------------------------------------------
  // Flow control. All stages advance together unless a finished result is
  // held by the receiver.
  // --------------------------------------------------------------------------
  logic out_vld_q;
  logic advance;

  assign advance    = !(out_vld_q && out_stall_i);
  assign in_stall_o = !advance;

  // Stage 1: offset from the camera, exact in 33 bits.
  logic               s1_vld_q;
  logic signed [32:0] dx_q, dy_q, dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (advance) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      dx_q <= 33'(point_x_i) - 33'(cam_x_q);
      dy_q <= 33'(point_y_i) - 33'(cam_y_q);
      dz_q <= 33'(point_z_i) - 33'(cam_z_q);
    end
  end

  // Stage 2: squares for the range test and the rotation products.
  logic               s2_vld_q;
  logic [65:0]        sq_x_q, sq_y_q, sq_z_q;
  logic signed [63:0] px1_q, px2_q, py1_q, py2_q, py3_q, pz1_q, pz2_q, pz3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (advance) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      sq_x_q <= 66'(66'(dx_q) * 66'(dx_q));
      sq_y_q <= 66'(66'(dy_q) * 66'(dy_q));
      sq_z_q <= 66'(66'(dz_q) * 66'(dz_q));
      px1_q  <= 64'(ca_q) * 64'(dx_q);
      px2_q  <= 64'(sa_q) * 64'(dz_q);
      py1_q  <= 64'(k_sasb_q) * 64'(dx_q);
      py2_q  <= 64'(cb_q) * 64'(dy_q);
      py3_q  <= 64'(k_casb_q) * 64'(dz_q);
      pz1_q  <= 64'(k_sacb_q) * 64'(dx_q);
      pz2_q  <= 64'(sb_q) * 64'(dy_q);
      pz3_q  <= 64'(k_cacb_q) * 64'(dz_q);
    end
  end

  // Stage 3: range test and camera-frame coordinates, all at scale 2^44.
  logic               s3_vld_q;
  logic               s3_beyond_q;
  logic signed [63:0] xs_q, yp_q, zp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (advance) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s3_beyond_q <= (68'(sq_x_q) + 68'(sq_y_q) + 68'(sq_z_q)) > 68'(r2_q);
      xs_q        <= (px1_q - px2_q) <<< 14;
      yp_q        <= -(py1_q + (py2_q <<< 14) + py3_q);
      zp_q        <= -(pz1_q - (pz2_q <<< 14) + pz3_q);
    end
  end

  // Stage 4: magnitudes and quotient signs.
  logic              s4_vld_q;
  logic              s4_beyond_q, s4_zero_q, s4_negx_q, s4_negy_q;
  logic [MagW-1:0]   s4_nx_q, s4_ny_q, s4_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (advance) begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s4_beyond_q <= s3_beyond_q;
      s4_zero_q   <= (zp_q == '0);
      s4_negx_q   <= xs_q[63] ^ zp_q[63];
      s4_negy_q   <= yp_q[63] ^ zp_q[63];
      s4_nx_q     <= MagW'(xs_q[63] ? -xs_q : xs_q);
      s4_ny_q     <= MagW'(yp_q[63] ? -yp_q : yp_q);
      s4_d_q      <= MagW'(zp_q[63] ? -zp_q : zp_q);
    end
  end

  // Stage 5 (divider entry): a ratio of 32768 or more is out of the image.
  logic                  dv_vld_q  [NDiv+1];
  cfpt_pkg::flags_t      dv_flg_q  [NDiv+1];
  logic                  dv_negx_q [NDiv+1];
  logic                  dv_negy_q [NDiv+1];
  logic [MagW-1:0]       dv_d_q    [NDiv+1];
  logic [RemW-1:0]       dv_rx_q   [NDiv+1];
  logic [RemW-1:0]       dv_ry_q   [NDiv+1];
  logic [NDiv-1:0]       dv_qx_q   [NDiv+1];
  logic [NDiv-1:0]       dv_qy_q   [NDiv+1];

  logic [RemW-1:0] lim_d;
  assign lim_d = RemW'(s4_d_q) << 15;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else if (advance) begin
      dv_vld_q[0] <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      dv_flg_q[0].beyond <= s4_beyond_q;
      dv_flg_q[0].zero   <= s4_zero_q;
      dv_flg_q[0].ovf    <= (RemW'(s4_nx_q) >= lim_d) || (RemW'(s4_ny_q) >= lim_d);
      dv_negx_q[0]       <= s4_negx_q;
      dv_negy_q[0]       <= s4_negy_q;
      dv_d_q[0]          <= s4_d_q;
      dv_rx_q[0]         <= RemW'(s4_nx_q) << 16;
      dv_ry_q[0]         <= RemW'(s4_ny_q) << 16;
      dv_qx_q[0]         <= '0;
      dv_qy_q[0]         <= '0;
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  // Both ratios share the depth as divisor.
  for (genvar k = 0; k < NDiv; k++) begin : g_div
    localparam int Sh = NDiv - 1 - k;
    logic [RemW-1:0] dsh;
    logic            ge_x, ge_y;

    assign dsh  = RemW'(dv_d_q[k]) << Sh;
    assign ge_x = dv_rx_q[k] >= dsh;
    assign ge_y = dv_ry_q[k] >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k+1] <= 1'b0;
      end else if (advance) begin
        dv_vld_q[k+1] <= dv_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        dv_flg_q[k+1]  <= dv_flg_q[k];
        dv_negx_q[k+1] <= dv_negx_q[k];
        dv_negy_q[k+1] <= dv_negy_q[k];
        dv_d_q[k+1]    <= dv_d_q[k];
        dv_rx_q[k+1]   <= ge_x ? dv_rx_q[k] - dsh : dv_rx_q[k];
        dv_ry_q[k+1]   <= ge_y ? dv_ry_q[k] - dsh : dv_ry_q[k];
        dv_qx_q[k+1]   <= {dv_qx_q[k][NDiv-2:0], ge_x};
        dv_qy_q[k+1]   <= {dv_qy_q[k][NDiv-2:0], ge_y};
      end
    end
  end

  // Ratio stage: signed Q15.16 ratios.
  logic               rt_vld_q;
  cfpt_pkg::flags_t   rt_flg_q;
  logic signed [31:0] rt_x_q, rt_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_vld_q <= 1'b0;
    end else if (advance) begin
      rt_vld_q <= dv_vld_q[NDiv];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rt_flg_q <= dv_flg_q[NDiv];
      rt_x_q   <= dv_negx_q[NDiv] ? 32'(0) - {1'b0, dv_qx_q[NDiv]} : {1'b0, dv_qx_q[NDiv]};
      rt_y_q   <= dv_negy_q[NDiv] ? 32'(0) - {1'b0, dv_qy_q[NDiv]} : {1'b0, dv_qy_q[NDiv]};
    end
  end

  // Pixel stage: u and v in Q.16.
  logic                  px_vld_q;
  cfpt_pkg::flags_t      px_flg_q;
  logic signed [PixW-1:0] pu_q, pv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_vld_q <= 1'b0;
    end else if (advance) begin
      px_vld_q <= rt_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      px_flg_q <= rt_flg_q;
      pu_q     <= PixW'(FOCAL_X) * PixW'(rt_x_q) + (PixW'(CENTER_X) <<< 16);
      pv_q     <= PixW'(FOCAL_Y) * PixW'(rt_y_q) + (PixW'(CENTER_Y) <<< 16);
    end
  end

  // Output register: tests in order range, zero depth, image bounds.
  logic              in_image;
  cfpt_pkg::reason_e reason_d, reason_q;

  assign in_image = !pu_q[PixW-1] && (pu_q <= PixW'(UpperX)) &&
                    !pv_q[PixW-1] && (pv_q <= PixW'(UpperY));

  always_comb begin
    priority if (px_flg_q.beyond) begin
      reason_d = cfpt_pkg::REASON_RANGE;
    end else if (px_flg_q.zero) begin
      reason_d = cfpt_pkg::REASON_DEPTH;
    end else if (px_flg_q.ovf || !in_image) begin
      reason_d = cfpt_pkg::REASON_IMAGE;
    end else begin
      reason_d = cfpt_pkg::REASON_VISIBLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= px_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      reason_q <= reason_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign reject_reason_o = reason_q;
  assign in_view_o       = (reason_q == cfpt_pkg::REASON_VISIBLE);

endmodule

/* src/cfpt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera frustum point test checker
// Port-level assertions on the handshake and result encoding.
// ----------------------------------------------------------------------------
module cfpt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       in_view_o,
  input logic [1:0] reject_reason_o
);

  // A held result stays presented.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // A held result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(reject_reason_o) && $stable(in_view_o))
    else $error("result item changed while stalled");

  // in_view is exactly the visible code.
  a_view_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (in_view_o == (reject_reason_o == cfpt_pkg::REASON_VISIBLE)))
    else $error("in_view disagrees with reject reason");

  // The input is only stalled by a waiting, stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

endmodule

bind camera_frustum_point_test_top cfpt_checker u_cfpt_checker (.*);
